### design/sdice_pkg.sv
// ============================================================================
// sdice_pkg
// Shared constants, state encoding and controller/datapath interface types
// for the per-slice Dice statistics core.
// ============================================================================
package sdice_pkg;

    localparam int unsigned MAX_SLICE_VOXELS_DEF = 1048576;
    localparam int unsigned MAX_SLICES_DEF       = 1024;

    localparam int unsigned VAL_W   = 16;   // voxel label width
    localparam int unsigned DICE_W  = 16;   // internal Dice width, 200 percent fits
    localparam int unsigned OUT_W   = 15;   // reported field width
    localparam int unsigned WIDE_W  = 64;   // variance path width, wraps modulo 2^64
    localparam int unsigned ROOT_W  = 32;   // integer root of a 64-bit value

    localparam logic [DICE_W-1:0] DICE_SCALE = 16'd51200;  // 200 percent in Q8.8
    localparam logic [WIDE_W-1:0] ROOT_TOP   = 64'h4000_0000_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_DIV_DICE_GO,
        ST_DIV_DICE,
        ST_SQUARE,
        ST_UPDATE,
        ST_STATS,
        ST_MUL_N,
        ST_MUL_S,
        ST_ROOT_GO,
        ST_ROOT,
        ST_DIV_MEAN,
        ST_DIV_SD,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        DIV_DICE,
        DIV_MEAN,
        DIV_SD
    } div_sel_t;

    typedef struct packed {
        logic     count;
        logic     scale;
        logic     div_start;
        div_sel_t div_sel;
        logic     square;
        logic     update;
        logic     mul_n_start;
        logic     mul_s_start;
        logic     mul_step;
        logic     diff;
        logic     root_start;
        logic     root_step;
        logic     finish;
    } cmd_t;

    typedef struct packed {
        logic kept;
        logic vend;
        logic stats_nz;
        logic div_done;
        logic mul_busy;
        logic root_busy;
        logic out_free;
    } status_t;

endpackage

### design/sdice_div.sv
// ============================================================================
// sdice_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module sdice_div
    import sdice_pkg::*;
#(
    parameter int unsigned NUM_W = 37,
    parameter int unsigned DEN_W = 22
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W:0]   rem_sub;

    assign rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
    assign ge      = (rem_sh >= {1'b0, den_reg});
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(NUM_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == CNT_W'(1));
            end
        end
    end

    // Shift the numerator out at the top, the quotient in at the bottom.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

### design/sdice_datapath.sv
// ============================================================================
// sdice_datapath
// Voxel counters, slice statistics, serial multiplier, integer root,
// divider and result register.
// ============================================================================
module sdice_datapath
    import sdice_pkg::*;
#(
    parameter int unsigned MAX_SLICE_VOXELS = MAX_SLICE_VOXELS_DEF,
    parameter int unsigned MAX_SLICES       = MAX_SLICES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output status_t                 status,
    input  logic signed [VAL_W-1:0] value_a,
    input  logic signed [VAL_W-1:0] value_b,
    input  logic                    slice_end,
    input  logic                    volume_end,
    input  logic                    result_stall,
    output logic                    result_valid,
    output logic [OUT_W-1:0]        slice_dice,
    output logic                    slice_kept,
    output logic                    volume_done,
    output logic [OUT_W-1:0]        mean_dice,
    output logic [OUT_W-1:0]        stdev_dice,
    output logic                    stats_valid
);

    localparam int unsigned CW  = $clog2(MAX_SLICE_VOXELS + 1);
    localparam int unsigned TW  = CW + 1;
    localparam int unsigned OVN = DICE_W + CW;
    localparam int unsigned NW  = $clog2(MAX_SLICES + 1);
    localparam int unsigned SW  = DICE_W + NW;
    localparam int unsigned SQW = 2 * DICE_W + NW;
    localparam int unsigned DNW_A = (OVN > SW) ? OVN : SW;
    localparam int unsigned DNW = (DNW_A > ROOT_W) ? DNW_A : ROOT_W;
    localparam int unsigned DDW = (TW > NW) ? TW : NW;

    localparam logic [CW-1:0] VOX_MAX = CW'(MAX_SLICE_VOXELS);
    localparam logic [NW-1:0] SLC_MAX = NW'(MAX_SLICES);

    // slice counters and statistics
    logic [CW-1:0]  cnt_a_reg, cnt_b_reg, cnt_o_reg;
    logic [TW-1:0]  total_reg;
    logic [CW-1:0]  ovl_reg;
    logic           vend_reg;
    logic [NW-1:0]  kept_reg;
    logic [SW-1:0]  sum_reg;
    logic [SQW-1:0] sq_reg;

    // working registers
    logic [OVN-1:0]      num_reg;
    logic [DICE_W-1:0]   dice_reg;
    logic [2*DICE_W-1:0] dsq_reg;
    logic [OUT_W-1:0]    mean_reg;
    logic [OUT_W-1:0]    sdev_reg;
    logic [WIDE_W-1:0]   acc_reg;
    logic [WIDE_W-1:0]   ma_reg;
    logic [SW-1:0]       mb_reg;
    logic [WIDE_W-1:0]   prodn_reg;
    logic [WIDE_W-1:0]   v_reg;
    logic [WIDE_W-1:0]   root_reg;
    logic [WIDE_W-1:0]   bit_reg;
    div_sel_t            div_sel_reg;

    // result register
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_dice_reg;
    logic             out_kept_reg;
    logic             out_vend_reg;
    logic [OUT_W-1:0] out_mean_reg;
    logic [OUT_W-1:0] out_sdev_reg;
    logic             out_stats_reg;

    logic          in_a, in_b;
    logic [CW-1:0] cnt_a_next, cnt_b_next, cnt_o_next;
    logic [WIDE_W-1:0] trial;
    logic [DNW-1:0]    div_num;
    logic [DDW-1:0]    div_den;
    logic              div_done;
    logic [DNW-1:0]    div_quot;

    assign in_a = (value_a > 16'sd0);
    assign in_b = (value_b > 16'sd0);

    // Saturate each count at the slice limit.
    assign cnt_a_next = (in_a && cnt_a_reg < VOX_MAX) ? cnt_a_reg + 1'b1 : cnt_a_reg;
    assign cnt_b_next = (in_b && cnt_b_reg < VOX_MAX) ? cnt_b_reg + 1'b1 : cnt_b_reg;
    assign cnt_o_next = (in_a && in_b && cnt_o_reg < VOX_MAX) ? cnt_o_reg + 1'b1
                                                              : cnt_o_reg;

    assign trial = root_reg + bit_reg;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_DICE:
            begin
                div_num = DNW'(num_reg);
                div_den = DDW'(total_reg);
            end
            DIV_MEAN:
            begin
                div_num = DNW'(sum_reg);
                div_den = DDW'(kept_reg);
            end
            DIV_SD:
            begin
                div_num = DNW'(root_reg[ROOT_W-1:0]);
                div_den = DDW'(kept_reg);
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    sdice_div #(
        .NUM_W (DNW),
        .DEN_W (DDW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // counters, statistics and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            cnt_o_reg     <= '0;
            kept_reg      <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.count)
            begin
                if (slice_end)
                begin
                    cnt_a_reg <= '0;
                    cnt_b_reg <= '0;
                    cnt_o_reg <= '0;
                end
                else
                begin
                    cnt_a_reg <= cnt_a_next;
                    cnt_b_reg <= cnt_b_next;
                    cnt_o_reg <= cnt_o_next;
                end
            end

            if (cmd.update && status.kept && kept_reg < SLC_MAX)
            begin
                kept_reg <= kept_reg + 1'b1;
                sum_reg  <= sum_reg + SW'(dice_reg);
                sq_reg   <= sq_reg + SQW'(dsq_reg);
            end
            else if (cmd.finish && vend_reg)
            begin
                kept_reg <= '0;
                sum_reg  <= '0;
                sq_reg   <= '0;
            end

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // snapshots, arithmetic and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.count && slice_end)
        begin
            total_reg <= TW'(cnt_a_next) + TW'(cnt_b_next);
            ovl_reg   <= cnt_o_next;
            vend_reg  <= volume_end;
        end

        if (cmd.scale)
        begin
            num_reg  <= OVN'(DICE_SCALE) * OVN'(ovl_reg);
            dice_reg <= '0;
        end

        if (cmd.div_start)
        begin
            div_sel_reg <= cmd.div_sel;
        end

        if (div_done)
        begin
            case (div_sel_reg)
                DIV_DICE: dice_reg <= div_quot[DICE_W-1:0];
                DIV_MEAN: mean_reg <= div_quot[OUT_W-1:0];
                DIV_SD:   sdev_reg <= div_quot[OUT_W-1:0];
                default:  dice_reg <= dice_reg;
            endcase
        end

        if (cmd.square)
        begin
            dsq_reg <= dice_reg * dice_reg;
        end

        // shift-add multiply, products wrap at 64 bits
        if (cmd.mul_n_start)
        begin
            acc_reg <= '0;
            ma_reg  <= WIDE_W'(sq_reg);
            mb_reg  <= SW'(kept_reg);
        end
        else if (cmd.mul_s_start)
        begin
            prodn_reg <= acc_reg;
            acc_reg   <= '0;
            ma_reg    <= WIDE_W'(sum_reg);
            mb_reg    <= sum_reg;
        end
        else if (cmd.mul_step)
        begin
            if (mb_reg[0])
            begin
                acc_reg <= acc_reg + ma_reg;
            end
            ma_reg <= ma_reg << 1;
            mb_reg <= mb_reg >> 1;
        end

        if (cmd.diff)
        begin
            v_reg <= (prodn_reg > acc_reg) ? prodn_reg - acc_reg : '0;
        end
        else if (cmd.root_step)
        begin
            if (v_reg >= trial)
            begin
                v_reg <= v_reg - trial;
            end
        end

        if (cmd.root_start)
        begin
            root_reg <= '0;
            bit_reg  <= ROOT_TOP;
        end
        else if (cmd.root_step)
        begin
            root_reg <= (v_reg >= trial) ? (root_reg >> 1) + bit_reg : root_reg >> 1;
            bit_reg  <= bit_reg >> 2;
        end

        if (cmd.finish)
        begin
            out_dice_reg  <= dice_reg[OUT_W-1:0];
            out_kept_reg  <= status.kept;
            out_vend_reg  <= vend_reg;
            out_stats_reg <= vend_reg && status.stats_nz;
            out_mean_reg  <= (vend_reg && status.stats_nz) ? mean_reg : '0;
            out_sdev_reg  <= (vend_reg && status.stats_nz) ? sdev_reg : '0;
        end
    end

    assign status.kept      = (total_reg != '0);
    assign status.vend      = vend_reg;
    assign status.stats_nz  = (kept_reg != '0);
    assign status.div_done  = div_done;
    assign status.mul_busy  = (mb_reg != '0);
    assign status.root_busy = (bit_reg != '0);
    assign status.out_free  = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign slice_dice   = out_dice_reg;
    assign slice_kept   = out_kept_reg;
    assign volume_done  = out_vend_reg;
    assign mean_dice    = out_mean_reg;
    assign stdev_dice   = out_sdev_reg;
    assign stats_valid  = out_stats_reg;

endmodule

### design/sdice_ctrl.sv
// ============================================================================
// sdice_ctrl
// Sequencer: counts voxels in idle, then steps the datapath through the
// slice and volume closing arithmetic.
// ============================================================================
module sdice_ctrl
    import sdice_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    voxel_valid,
    input  logic    slice_end,
    input  status_t status,
    output logic    voxel_stall,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_sel = DIV_DICE;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.count = voxel_valid;
                if (voxel_valid && slice_end)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = status.kept ? ST_DIV_DICE_GO : ST_UPDATE;
            end
            ST_DIV_DICE_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_DICE;
            end
            ST_DIV_DICE:
            begin
                if (status.div_done)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = status.vend ? ST_STATS : ST_FINISH;
            end
            ST_STATS:
            begin
                if (status.stats_nz)
                begin
                    cmd.mul_n_start = 1'b1;
                    state_next      = ST_MUL_N;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL_N:
            begin
                if (status.mul_busy)
                begin
                    cmd.mul_step = 1'b1;
                end
                else
                begin
                    cmd.mul_s_start = 1'b1;
                    state_next      = ST_MUL_S;
                end
            end
            ST_MUL_S:
            begin
                if (status.mul_busy)
                begin
                    cmd.mul_step = 1'b1;
                end
                else
                begin
                    cmd.diff   = 1'b1;
                    state_next = ST_ROOT_GO;
                end
            end
            ST_ROOT_GO:
            begin
                cmd.root_start = 1'b1;
                state_next     = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (status.root_busy)
                begin
                    cmd.root_step = 1'b1;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_MEAN;
                    state_next    = ST_DIV_MEAN;
                end
            end
            ST_DIV_MEAN:
            begin
                if (status.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SD;
                    state_next    = ST_DIV_SD;
                end
            end
            ST_DIV_SD:
            begin
                if (status.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign voxel_stall = (state_reg != ST_IDLE);

endmodule

### design/slice_dice_statistics_core.sv
// ============================================================================
// slice_dice_statistics_core
// Per-slice Dice overlap of two label volumes with mean and population
// standard deviation of the kept slice values at each volume end.
// ============================================================================
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  voxel    | voxel_valid / voxel_stall  | value_a, value_b, slice_end,
//           |                            | volume_end
//  result   | result_valid/result_stall  | slice_dice, slice_kept, volume_done,
//           |                            | mean_dice, stdev_dice, stats_valid
//
//  Flow: voxels that do not end a slice stream at full rate while the
//  sequencer is idle. A slice end holds voxel_stall high through the closing
//  arithmetic, which includes the bit-serial divider of width DNW (the largest
//  of 16 + clog2(MAX_SLICE_VOXELS+1), 16 + clog2(MAX_SLICES+1) and 32), or only
//  through the scale, update and finish steps when both masks are empty. A
//  volume end adds the shift-add multiplies, which step through the significant
//  bits of the kept count and of the Dice sum, 32 root steps and two more divides.
//  Reset: rst_n clears the counters, the statistics, the sequencer and the
//  result valid at once; no clearing pass.
//  Stalls: a finished result waits in the output register while voxels keep
//  flowing; the next slice end is still taken, and its result waits in the
//  finish step only if that register is still full.
module slice_dice_statistics_core
    import sdice_pkg::*;
#(
    parameter int unsigned MAX_SLICE_VOXELS = MAX_SLICE_VOXELS_DEF,
    parameter int unsigned MAX_SLICES       = MAX_SLICES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    voxel_valid,
    output logic                    voxel_stall,
    input  logic signed [VAL_W-1:0] value_a,
    input  logic signed [VAL_W-1:0] value_b,
    input  logic                    slice_end,
    input  logic                    volume_end,

    output logic                    result_valid,
    input  logic                    result_stall,
    output logic [OUT_W-1:0]        slice_dice,
    output logic                    slice_kept,
    output logic                    volume_done,
    output logic [OUT_W-1:0]        mean_dice,
    output logic [OUT_W-1:0]        stdev_dice,
    output logic                    stats_valid
);

    cmd_t    cmd;
    status_t status;

    // Sequencer: accept voxels in idle, then walk the closing arithmetic.
    sdice_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .voxel_valid (voxel_valid),
        .slice_end   (slice_end),
        .status      (status),
        .voxel_stall (voxel_stall),
        .cmd         (cmd)
    );

    // Counters, accumulators, shared divider, multiplier, root and result register.
    sdice_datapath #(
        .MAX_SLICE_VOXELS (MAX_SLICE_VOXELS),
        .MAX_SLICES       (MAX_SLICES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .value_a      (value_a),
        .value_b      (value_b),
        .slice_end    (slice_end),
        .volume_end   (volume_end),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .slice_dice   (slice_dice),
        .slice_kept   (slice_kept),
        .volume_done  (volume_done),
        .mean_dice    (mean_dice),
        .stdev_dice   (stdev_dice),
        .stats_valid  (stats_valid)
    );

endmodule

### design/sdice_checker.sv
// ============================================================================
// sdice_checker
// Port-level checks of the Dice statistics core, bound to the top level.
// ============================================================================
module sdice_checker
    import sdice_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    voxel_valid,
    input logic                    voxel_stall,
    input logic signed [VAL_W-1:0] value_a,
    input logic signed [VAL_W-1:0] value_b,
    input logic                    slice_end,
    input logic                    volume_end,
    input logic                    result_valid,
    input logic                    result_stall,
    input logic [OUT_W-1:0]        slice_dice,
    input logic                    slice_kept,
    input logic                    volume_done,
    input logic [OUT_W-1:0]        mean_dice,
    input logic [OUT_W-1:0]        stdev_dice,
    input logic                    stats_valid
);

    // A slice end starts the closing arithmetic: hold off the next voxel.
    a_slice_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        voxel_valid && !voxel_stall && slice_end |=> voxel_stall)
        else $error("voxel accepted right after a slice end");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(slice_dice) && $stable(mean_dice)
            && $stable(stdev_dice) && $stable(volume_done))
        else $error("stalled result changed");

    // An excluded slice reports zero Dice.
    a_empty_slice_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !slice_kept |-> slice_dice == '0)
        else $error("excluded slice with nonzero Dice");

    // Statistics appear only on a volume close.
    a_stats_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && stats_valid |-> volume_done)
        else $error("statistics valid without volume end");

    // No valid statistics means zero mean and deviation.
    a_invalid_stats_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !stats_valid |-> mean_dice == '0 && stdev_dice == '0)
        else $error("nonzero statistics while not valid");

endmodule

bind slice_dice_statistics_core sdice_checker u_sdice_checker (.*);
